### rtl/assert_macros.svh
// Assertion macros for the classifier top level; every check is clocked on clk_i and off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, disabled while rst_ni is low.
`define IPAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a strobe follows its cause.
`define IPAC_ASSERT_FOLLOWS(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cause) |=> ##1 (effect)) else $error(msg);

`endif

### rtl/ipac_pkg.sv
// Package for the IP address classifier: result type, scope codes and range constants.
`timescale 1ns / 1ps
`default_nettype none

package ipac_pkg;

  localparam int unsigned AddrHalfW = 64;
  localparam int unsigned V4W       = 32;
  localparam int unsigned ScopeW    = 3;

  // IPv6 multicast scope codes on the result.
  localparam logic [ScopeW-1:0] SCOPE_NONE      = 3'd0;
  localparam logic [ScopeW-1:0] SCOPE_INTERFACE = 3'd1;
  localparam logic [ScopeW-1:0] SCOPE_LINK      = 3'd2;
  localparam logic [ScopeW-1:0] SCOPE_REALM     = 3'd3;
  localparam logic [ScopeW-1:0] SCOPE_ADMIN     = 3'd4;
  localparam logic [ScopeW-1:0] SCOPE_SITE      = 3'd5;
  localparam logic [ScopeW-1:0] SCOPE_ORG       = 3'd6;
  localparam logic [ScopeW-1:0] SCOPE_GLOBAL    = 3'd7;

  // Scope nibble values in the first IPv6 group.
  localparam logic [3:0] NIB_INTERFACE = 4'h1;
  localparam logic [3:0] NIB_LINK      = 4'h2;
  localparam logic [3:0] NIB_REALM     = 4'h3;
  localparam logic [3:0] NIB_ADMIN     = 4'h4;
  localparam logic [3:0] NIB_SITE      = 4'h5;
  localparam logic [3:0] NIB_ORG       = 4'h8;
  localparam logic [3:0] NIB_GLOBAL    = 4'he;

  localparam logic [15:0] V6_ULA_MASK   = 16'hfe00;
  localparam logic [15:0] V6_ULA_VAL    = 16'hfc00;
  localparam logic [15:0] V6_LL_MASK    = 16'hffc0;
  localparam logic [15:0] V6_LL_VAL     = 16'hfe80;
  localparam logic [15:0] V6_MC_MASK    = 16'hff00;
  localparam logic [15:0] V6_IETF_GRP   = 16'h2001;
  localparam logic [15:0] V6_DOC_GRP    = 16'h0db8;
  localparam logic [15:0] V6_XLAT_GRP0  = 16'h0064;
  localparam logic [15:0] V6_XLAT_GRP1  = 16'hff9b;
  localparam logic [15:0] V6_DISC_GRP   = 16'h0100;
  localparam logic [15:0] V6_AS112_GRP  = 16'h0112;
  localparam logic [15:0] V6_MAPPED_TAG = 16'hffff;
  localparam logic [63:0] V6_ANYCAST_HI = 64'h2001_0001_0000_0000;

  typedef struct packed {
    logic              unspecified;
    logic              loopback;
    logic              private_range;
    logic              link_local;
    logic              multicast;
    logic              documentation;
    logic              benchmarking;
    logic              global_res;
    logic              unicast_global;
    logic [ScopeW-1:0] scope_code;
    logic              mapped_valid;
    logic [V4W-1:0]    mapped_ipv4;
  } result_t;

endpackage

`default_nettype wire

### rtl/ip_address_classifier_top.sv
// Top level of the IP address classifier: input register, classifier and result register.
// Path: a beat taken at a clock edge passes the input register and then the result
//   register; result_valid_o is high while the result register holds its result.
// Throughput: one address per cycle; busy stays low, and the result register is
//   the only stage the classification logic feeds.
// Reset: rst_ni clears both valid flags at once; no result beat leaves during reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ip_address_classifier_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           is_v6_i,
  input  wire logic [ipac_pkg::AddrHalfW-1:0] addr_high_i,
  input  wire logic [ipac_pkg::AddrHalfW-1:0] addr_low_i,
  output logic                                result_valid_o,
  output logic                                unspecified_o,
  output logic                                loopback_o,
  output logic                                private_range_o,
  output logic                                link_local_o,
  output logic                                multicast_o,
  output logic                                documentation_o,
  output logic                                benchmarking_o,
  output logic                                global_res_o,
  output logic                                unicast_global_o,
  output logic [ipac_pkg::ScopeW-1:0]         scope_code_o,
  output logic                                mapped_valid_o,
  output logic [ipac_pkg::V4W-1:0]            mapped_ipv4_o
);

  logic                           accept;
  logic                           in_vld_q;
  logic                           is_v6_q;
  logic [ipac_pkg::AddrHalfW-1:0] addr_high_q;
  logic [ipac_pkg::AddrHalfW-1:0] addr_low_q;
  ipac_pkg::result_t              res_d;
  ipac_pkg::result_t              res_q;
  logic                           out_vld_q;

  // Both stages advance every cycle, so the block never has to hold a beat off.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= accept;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_v6_q     <= is_v6_i;
      addr_high_q <= addr_high_i;
      addr_low_q  <= addr_low_i;
    end
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  ipac_classify u_classify (
    .is_v6_i     (is_v6_q),
    .addr_high_i (addr_high_q),
    .addr_low_i  (addr_low_q),
    .res_o       (res_d)
  );

  assign result_valid_o   = out_vld_q;
  assign unspecified_o    = res_q.unspecified;
  assign loopback_o       = res_q.loopback;
  assign private_range_o  = res_q.private_range;
  assign link_local_o     = res_q.link_local;
  assign multicast_o      = res_q.multicast;
  assign documentation_o  = res_q.documentation;
  assign benchmarking_o   = res_q.benchmarking;
  assign global_res_o     = res_q.global_res;
  assign unicast_global_o = res_q.unicast_global;
  assign scope_code_o     = res_q.scope_code;
  assign mapped_valid_o   = res_q.mapped_valid;
  assign mapped_ipv4_o    = res_q.mapped_ipv4;

  `IPAC_ASSERT_FOLLOWS(a_beat_to_result, accept, result_valid_o,
                       "accepted beat gave no result")
  `IPAC_ASSERT(a_result_has_cause, result_valid_o |-> $past(accept, 2),
               "result without a beat")
  `IPAC_ASSERT(a_mapped_zero,
               (result_valid_o && !mapped_valid_o) |-> (mapped_ipv4_o == '0),
               "mapped_ipv4 set while not mapped")
  `IPAC_ASSERT(a_scope_needs_mc,
               (result_valid_o && scope_code_o != ipac_pkg::SCOPE_NONE) |-> multicast_o,
               "scope on a non-multicast address")

endmodule

`default_nettype wire

### rtl/ipac_classify.sv
// Combinational IPv4 / IPv6 special-address classification of one registered address.
`timescale 1ns / 1ps
`default_nettype none

module ipac_classify (
  input  wire logic                          is_v6_i,
  input  wire logic [ipac_pkg::AddrHalfW-1:0] addr_high_i,
  input  wire logic [ipac_pkg::AddrHalfW-1:0] addr_low_i,
  output ipac_pkg::result_t                  res_o
);

  logic [7:0]  o0, o1, o2;
  logic        v4_priv, v4_loop, v4_ll, v4_mc, v4_doc, v4_bench;
  logic        v4_shared, v4_bcast, v4_resv, v4_ietf, v4_glob;

  logic [15:0] s0, s1, s2, s3;
  logic        v6_unspec, v6_loop, v6_ula, v6_ll, v6_mc, v6_doc, v6_bench;
  logic        v6_mapped, v6_xlat, v6_discard, v6_anycast, v6_ietf_ok, v6_ietf;
  logic        v6_glob;
  logic [ipac_pkg::ScopeW-1:0] v6_scope;

  // IPv4 checks on addr_low[31:0].
  assign o0 = addr_low_i[31:24];
  assign o1 = addr_low_i[23:16];
  assign o2 = addr_low_i[15:8];

  assign v4_priv   = (o0 == 8'd10) || (o0 == 8'd172 && o1[7:4] == 4'h1)
                   || (o0 == 8'd192 && o1 == 8'd168);
  assign v4_loop   = (o0 == 8'd127);
  assign v4_ll     = (o0 == 8'd169 && o1 == 8'd254);
  assign v4_mc     = (o0[7:4] == 4'he);
  assign v4_doc    = (o0 == 8'd192 && o1 == 8'd0 && o2 == 8'd2)
                   || (o0 == 8'd198 && o1 == 8'd51 && o2 == 8'd100)
                   || (o0 == 8'd203 && o1 == 8'd0 && o2 == 8'd113);
  assign v4_bench  = (o0 == 8'd198 && o1[7:1] == 7'd9);
  assign v4_shared = (o0 == 8'd100 && o1[7:6] == 2'b01);
  assign v4_bcast  = (addr_low_i[31:0] == 32'hffff_ffff);
  assign v4_resv   = (o0[7:4] == 4'hf) && !v4_bcast;
  assign v4_ietf   = (o0 == 8'd192 && o1 == 8'd0 && o2 == 8'd0);
  assign v4_glob   = !((o0 == 8'd0) || v4_priv || v4_shared || v4_loop || v4_ll
                   || v4_ietf || v4_doc || v4_bench || v4_resv || v4_bcast);

  // IPv6 checks on the 16-bit groups, first group in the top bits.
  assign s0 = addr_high_i[63:48];
  assign s1 = addr_high_i[47:32];
  assign s2 = addr_high_i[31:16];
  assign s3 = addr_high_i[15:0];

  assign v6_unspec  = (addr_high_i == '0) && (addr_low_i == '0);
  assign v6_loop    = (addr_high_i == '0) && (addr_low_i == 64'd1);
  assign v6_ula     = ((s0 & ipac_pkg::V6_ULA_MASK) == ipac_pkg::V6_ULA_VAL);
  assign v6_ll      = ((s0 & ipac_pkg::V6_LL_MASK) == ipac_pkg::V6_LL_VAL);
  assign v6_mc      = ((s0 & ipac_pkg::V6_MC_MASK) == ipac_pkg::V6_MC_MASK);
  assign v6_doc     = (s0 == ipac_pkg::V6_IETF_GRP) && (s1 == ipac_pkg::V6_DOC_GRP);
  assign v6_bench   = (s0 == ipac_pkg::V6_IETF_GRP) && (s1 == 16'h0002) && (s2 == 16'h0000);
  assign v6_mapped  = (addr_high_i == '0) && (addr_low_i[63:32] == 32'h0000_ffff);
  assign v6_xlat    = (s0 == ipac_pkg::V6_XLAT_GRP0) && (s1 == ipac_pkg::V6_XLAT_GRP1)
                    && (s2 == 16'h0001);
  assign v6_discard = (s0 == ipac_pkg::V6_DISC_GRP) && (s1 == 16'h0000)
                    && (s2 == 16'h0000) && (s3 == 16'h0000);
  assign v6_anycast = (addr_high_i == ipac_pkg::V6_ANYCAST_HI)
                    && ((addr_low_i == 64'd1) || (addr_low_i == 64'd2));
  assign v6_ietf_ok = v6_anycast
                    || (s0 == ipac_pkg::V6_IETF_GRP && s1 == 16'h0003)
                    || (s0 == ipac_pkg::V6_IETF_GRP && s1 == 16'h0004
                        && s2 == ipac_pkg::V6_AS112_GRP)
                    || (s0 == ipac_pkg::V6_IETF_GRP && s1[15:4] == 12'h002);
  // 2001::/23 means the second group is below 0x200.
  assign v6_ietf    = (s0 == ipac_pkg::V6_IETF_GRP) && (s1[15:9] == 7'd0) && !v6_ietf_ok;
  assign v6_glob    = !(v6_unspec || v6_loop || v6_mapped || v6_xlat || v6_discard
                    || v6_ietf || v6_doc || v6_ula || v6_ll);

  always_comb begin
    v6_scope = ipac_pkg::SCOPE_NONE;
    if (v6_mc) begin
      case (s0[3:0])
        ipac_pkg::NIB_INTERFACE: v6_scope = ipac_pkg::SCOPE_INTERFACE;
        ipac_pkg::NIB_LINK:      v6_scope = ipac_pkg::SCOPE_LINK;
        ipac_pkg::NIB_REALM:     v6_scope = ipac_pkg::SCOPE_REALM;
        ipac_pkg::NIB_ADMIN:     v6_scope = ipac_pkg::SCOPE_ADMIN;
        ipac_pkg::NIB_SITE:      v6_scope = ipac_pkg::SCOPE_SITE;
        ipac_pkg::NIB_ORG:       v6_scope = ipac_pkg::SCOPE_ORG;
        ipac_pkg::NIB_GLOBAL:    v6_scope = ipac_pkg::SCOPE_GLOBAL;
        default:                 v6_scope = ipac_pkg::SCOPE_NONE;
      endcase
    end
  end

  always_comb begin
    res_o = '0;
    if (is_v6_i) begin
      res_o.unspecified    = v6_unspec;
      res_o.loopback       = v6_loop;
      res_o.private_range  = v6_ula;
      res_o.link_local     = v6_ll;
      res_o.multicast      = v6_mc;
      res_o.documentation  = v6_doc;
      res_o.benchmarking   = v6_bench;
      res_o.global_res     = v6_glob;
      res_o.unicast_global = !v6_mc && !v6_loop && !v6_ll && !v6_ula && !v6_unspec
                             && !v6_doc && !v6_bench;
      res_o.scope_code     = v6_scope;
      res_o.mapped_valid   = v6_mapped;
      res_o.mapped_ipv4    = v6_mapped ? addr_low_i[31:0] : '0;
    end else begin
      res_o.unspecified    = (addr_low_i[31:0] == '0);
      res_o.loopback       = v4_loop;
      res_o.private_range  = v4_priv;
      res_o.link_local     = v4_ll;
      res_o.multicast      = v4_mc;
      res_o.documentation  = v4_doc;
      res_o.benchmarking   = v4_bench;
      res_o.global_res     = v4_glob;
    end
  end

endmodule

`default_nettype wire
